>>> src/spfm_pkg.sv
package spfm_pkg;

    localparam int unsigned POOL_FRAMES     = 16;
    localparam int unsigned PAGES_PER_SPACE = 32;
    localparam int unsigned PAGE_BYTES      = 4096;

    localparam int unsigned FRAME_W    = $clog2(POOL_FRAMES);
    localparam int unsigned PAGE_W     = $clog2(PAGES_PER_SPACE);
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned SID_W      = 6;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned VPN_LSB    = 12;
    localparam int unsigned VPN_W      = 20;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_HIT       = 2'd0,
        STAT_LOAD_FREE = 2'd1,
        STAT_EVICT     = 2'd2,
        STAT_TRAP      = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic {
        REG_POOL_BASE = 1'b0,
        REG_PREFER    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SID_W-1:0]  space_id;
        logic [ADDR_W-1:0] entry_high;
        logic              is_modify_fault;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  page_index;
        logic [FRAME_W-1:0] frame_index;
        logic [ADDR_W-1:0]  frame_address;
        logic [SID_W-1:0]   victim_space_id;
        logic [PAGE_W-1:0]  victim_page;
    } out_item_t;

    // Search token walking the cell row, one cell per cycle
    typedef struct packed {
        logic               valid;
        logic [SID_W-1:0]   sid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] rr;
        logic               hit;
        logic [FRAME_W-1:0] hit_idx;
        logic               free_found;
        logic [FRAME_W-1:0] free_idx;
        logic               rr_occ;
        logic [SID_W-1:0]   rr_owner;
        logic [PAGE_W-1:0]  rr_page;
    } probe_t;

    // Owner update broadcast to all cells
    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] idx;
        logic [SID_W-1:0]   sid;
        logic [PAGE_W-1:0]  page;
    } commit_t;

endpackage

>>> src/swap_pool_frame_manager_core.sv
// Path from input accept to result valid: launch register, the 16 frame cells,
//   then the hold register and the decision into the output register.
// One item at a time: a new item is taken only after the last result is issued,
//   set by the token walk along the row; output stalls hide behind the next search.
// Reset (aresetn low, synchronous): all frames free, round-robin pointer 0,
//   pool base 0, free-frame preference on, no item in flight, output empty.
module swap_pool_frame_manager_core (
    input  logic                aclk,
    input  logic                aresetn,
    // fault item in
    input  logic                s_valid,
    output logic                s_ready,
    input  spfm_pkg::in_item_t  s_data,
    // result item out
    output logic                m_valid,
    input  logic                m_ready,
    output spfm_pkg::out_item_t m_data,
    // configuration writes
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import spfm_pkg::*;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_SCAN = 3'b010,
        FSM_DONE = 3'b100
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    // config registers
    logic [ADDR_W-1:0]  pool_base_reg;
    logic               prefer_reg;

    logic [FRAME_W-1:0] rr_reg, rr_next;

    // item bookkeeping
    logic               modf_reg;
    probe_t             launch_reg, launch_next;
    probe_t             hold_reg;

    out_item_t          out_reg, out_next;
    logic               m_valid_reg;

    commit_t            commit;
    logic               accept;
    logic               finish;

    // chain taps: tap[0] feeds cell 0, tap[POOL_FRAMES] is the row's tail
    probe_t             tap [POOL_FRAMES+1];

    logic [VPN_W-1:0]   in_vpn;
    logic [PAGE_W-1:0]  in_page;

    assign accept = s_valid && s_ready;
    assign s_ready = (fsm_reg == FSM_IDLE);
    // decision issues once the output slot is free
    assign finish = (fsm_reg == FSM_DONE) && (!m_valid_reg || m_ready);

    // page index: low VPN bits, stack page (all-ones VPN) goes to the last page
    assign in_vpn  = s_data.entry_high[VPN_LSB +: VPN_W];
    assign in_page = (&in_vpn) ? PAGE_W'(PAGES_PER_SPACE - 1) : in_vpn[PAGE_W-1:0];

    always_comb begin
        launch_next            = '0;
        launch_next.valid      = accept;
        launch_next.sid        = s_data.space_id;
        launch_next.page       = in_page;
        launch_next.rr         = rr_reg;
    end

    // frame cell row
    assign tap[0] = launch_reg;

    for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_cell
        spfm_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .probe_i  (tap[g]),
            .probe_o  (tap[g+1]),
            .commit_i (commit)
        );
    end

    // decision from the token that reached the tail
    always_comb begin
        commit      = '0;
        commit.sid  = hold_reg.sid;
        commit.page = hold_reg.page;
        rr_next     = rr_reg;
        out_next    = '0;
        out_next.page_index = hold_reg.page;
        if (modf_reg) begin
            out_next.status = STAT_TRAP;
        end else begin
            if (hold_reg.hit) begin
                out_next.status      = STAT_HIT;
                out_next.frame_index = hold_reg.hit_idx;
            end else if (prefer_reg && hold_reg.free_found) begin
                out_next.status      = STAT_LOAD_FREE;
                out_next.frame_index = hold_reg.free_idx;
                commit.we            = 1'b1;
            end else begin
                out_next.frame_index = hold_reg.rr;
                commit.we            = 1'b1;
                rr_next = (hold_reg.rr == FRAME_W'(POOL_FRAMES - 1)) ? '0
                        : hold_reg.rr + FRAME_W'(1);
                if (hold_reg.rr_occ) begin
                    out_next.status          = STAT_EVICT;
                    out_next.victim_space_id = hold_reg.rr_owner;
                    out_next.victim_page     = hold_reg.rr_page;
                end else begin
                    out_next.status = STAT_LOAD_FREE;
                end
            end
            out_next.frame_address = pool_base_reg
                + (ADDR_W'(out_next.frame_index) << PAGE_SHIFT);
        end
        commit.idx = out_next.frame_index;
        commit.we  = commit.we && finish;
        if (!finish) begin
            rr_next = rr_reg;
        end
    end

    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE: begin
                if (accept) begin
                    fsm_next = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (tap[POOL_FRAMES].valid) begin
                    fsm_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (finish) begin
                    fsm_next = FSM_IDLE;
                end
            end
            default: fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg          <= FSM_IDLE;
            pool_base_reg    <= '0;
            prefer_reg       <= 1'b1;
            rr_reg           <= '0;
            launch_reg.valid <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            fsm_reg    <= fsm_next;
            rr_reg     <= rr_next;
            launch_reg <= launch_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_POOL_BASE: pool_base_reg <= cfg_data;
                    REG_PREFER:    prefer_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            modf_reg <= s_data.is_modify_fault;
        end
        if (fsm_reg == FSM_SCAN && tap[POOL_FRAMES].valid) begin
            hold_reg <= tap[POOL_FRAMES];
        end
        if (finish) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // the token reaches the tail only while the controller waits for it
    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tap[POOL_FRAMES].valid |-> fsm_reg == FSM_SCAN)
        else $error("search token at row tail outside scan");

    // no eviction report means no victim fields
    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_EVICT |->
            m_data.victim_space_id == '0 && m_data.victim_page == '0)
        else $error("victim fields set without eviction");

    // frame table changes only for a miss that is not a modification fault
    a_commit_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        commit.we |-> !modf_reg && !hold_reg.hit)
        else $error("frame table written on hit or trap");

    // one item in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted twice in a row");

endmodule

>>> src/spfm_cell.sv
module spfm_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  spfm_pkg::probe_t  probe_i,
    output spfm_pkg::probe_t  probe_o,
    input  spfm_pkg::commit_t commit_i
);
    import spfm_pkg::*;

    localparam logic [FRAME_W-1:0] MY_IDX = FRAME_W'(CELL_IDX);

    logic               occ_reg;
    logic [SID_W-1:0]   owner_reg;
    logic [PAGE_W-1:0]  page_reg;
    probe_t             probe_reg;
    probe_t             probe_next;

    always_comb begin
        probe_next = probe_i;
        if (!probe_i.hit && occ_reg && owner_reg == probe_i.sid
                && page_reg == probe_i.page) begin
            probe_next.hit     = 1'b1;
            probe_next.hit_idx = MY_IDX;
        end
        if (!probe_i.free_found && !occ_reg) begin
            probe_next.free_found = 1'b1;
            probe_next.free_idx   = MY_IDX;
        end
        if (probe_i.rr == MY_IDX) begin
            probe_next.rr_occ   = occ_reg;
            probe_next.rr_owner = owner_reg;
            probe_next.rr_page  = page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg         <= 1'b0;
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg <= probe_next;
            if (commit_i.we && commit_i.idx == MY_IDX) begin
                occ_reg <= 1'b1;
            end
        end
    end

    // owner/page: no reset, only read while occupied
    always_ff @(posedge aclk) begin
        if (commit_i.we && commit_i.idx == MY_IDX) begin
            owner_reg <= commit_i.sid;
            page_reg  <= commit_i.page;
        end
    end

    assign probe_o = probe_reg;

endmodule
